### hw/rtl/les_pkg.sv
`timescale 1ns / 1ps

package les_pkg;

    // coordinate and fixed-point formats
    localparam int COORD_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 16;
    localparam int TAB_FRAC       = 24;
    localparam int DIST_FRAC      = 8;
    localparam int OUT_BITS       = 18;

    // derived widths
    localparam int TAN_BITS     = TRIG_FRAC_BITS + 2;
    localparam int CS_BITS      = TRIG_FRAC_BITS + 1;
    localparam int MID_BITS     = COORD_BITS + TAN_BITS;
    localparam int SQR_BITS     = 2 * COORD_BITS;
    localparam int SUMSQ_BITS   = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS    = COORD_BITS + 1 + DIST_FRAC;
    localparam int RAD_BITS     = 2 * ROOT_BITS;
    localparam int REM_BITS     = ROOT_BITS + 3;
    localparam int PROD_BITS    = ROOT_BITS + CS_BITS;
    localparam int PROD_SHIFT   = DIST_FRAC + TRIG_FRAC_BITS;
    localparam int ACC_BITS     = PROD_BITS + 2;
    localparam int QUO_BITS     = ACC_BITS - PROD_SHIFT;
    localparam int CTR_BITS     = QUO_BITS + 2;
    localparam int TRIG_SHIFT   = TAB_FRAC - TRIG_FRAC_BITS;

    // square root: root bits resolved per pipeline stage
    localparam int SQ_PER_STAGE = 4;
    localparam int SQ_STAGES    = (ROOT_BITS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;

    // comparison slots between neighboring allowed angles
    localparam int NSLOT = 4;

    // pipeline stage positions
    localparam int ST_A     = 0;
    localparam int ST_B     = 1;
    localparam int ST_C     = 2;
    localparam int ST_SQ0   = 3;
    localparam int ST_D     = ST_SQ0 + SQ_STAGES;
    localparam int ST_E1    = ST_D + 1;
    localparam int ST_E2    = ST_D + 2;
    localparam int ST_F     = ST_D + 3;
    localparam int N_STAGES = ST_F + 1;

    // snapped angle
    typedef enum logic [2:0] {
        ANG_0  = 3'd0,
        ANG_30 = 3'd1,
        ANG_45 = 3'd2,
        ANG_60 = 3'd3,
        ANG_90 = 3'd4
    } ang_t;

    // item context that rides along the whole pipeline
    typedef struct packed {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic                         s45;
        logic                         s30;
        logic                         snap;
        logic                         ctr;
        logic                         negx;
        logic                         negy;
        logic                         dxz;
        ang_t                         ang;
    } ctx_t;

    // square root working state
    typedef struct packed {
        logic [RAD_BITS-1:0]  rad;
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
    } sq_t;

    // round a Q.24 table value half up to the trig format
    function automatic logic [63:0] to_trig(input logic [63:0] c);
        to_trig = (c + ((64'd1 << TRIG_SHIFT) >> 1)) >> TRIG_SHIFT;
    endfunction

    // tangent of each midpoint
    localparam logic [TAN_BITS-1:0] TAN_15   = TAN_BITS'(to_trig(64'd4495441));
    localparam logic [TAN_BITS-1:0] TAN_22_5 = TAN_BITS'(to_trig(64'd6949350));
    localparam logic [TAN_BITS-1:0] TAN_37_5 = TAN_BITS'(to_trig(64'd12873611));
    localparam logic [TAN_BITS-1:0] TAN_45   = TAN_BITS'(to_trig(64'd16777216));
    localparam logic [TAN_BITS-1:0] TAN_52_5 = TAN_BITS'(to_trig(64'd21864494));
    localparam logic [TAN_BITS-1:0] TAN_67_5 = TAN_BITS'(to_trig(64'd40503782));
    localparam logic [TAN_BITS-1:0] TAN_75   = TAN_BITS'(to_trig(64'd62613423));

    // cosine and sine of the diagonals
    localparam logic [CS_BITS-1:0] CS_30 = CS_BITS'(to_trig(64'd14529495));
    localparam logic [CS_BITS-1:0] CS_45 = CS_BITS'(to_trig(64'd11863283));
    localparam logic [CS_BITS-1:0] CS_60 = CS_BITS'(to_trig(64'd8388608));

    // output saturation bounds
    localparam logic signed [CTR_BITS-1:0] OUT_MAX_W =
        CTR_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [CTR_BITS-1:0] OUT_MIN_W = -OUT_MAX_W - CTR_BITS'(1);

    // one root bit of the restoring square root
    function automatic sq_t sqrt_step(input sq_t a);
        sq_t                 r;
        logic [REM_BITS-1:0] rem_sh;
        logic [REM_BITS-1:0] trial;
        rem_sh = {a.rem[REM_BITS-3:0], a.rad[RAD_BITS-1 -: 2]};
        trial  = REM_BITS'({a.root, 2'b01});
        r.rad  = {a.rad[RAD_BITS-3:0], 2'b00};
        if (rem_sh >= trial) begin
            r.rem  = rem_sh - trial;
            r.root = {a.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            r.rem  = rem_sh;
            r.root = {a.root[ROOT_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    // clamp to the output range
    function automatic logic signed [OUT_BITS-1:0] sat_out(
        input logic signed [CTR_BITS-1:0] v
    );
        if (v > OUT_MAX_W) begin
            sat_out = OUT_MAX_W[OUT_BITS-1:0];
        end else if (v < OUT_MIN_W) begin
            sat_out = OUT_MIN_W[OUT_BITS-1:0];
        end else begin
            sat_out = v[OUT_BITS-1:0];
        end
    endfunction

endpackage

### hw/rtl/line_endpoint_angle_snap.sv
`timescale 1ns / 1ps

// Line end point angle snap. Each transfer on the s_ side carries a line's start and end point
// plus the snap_45, snap_30 and centre modifiers; one transfer on the m_ side returns the
// resulting start and (snapped) end point, saturated to 18 bits. The block is a 14-stage
// pipeline at the default 16-bit coordinates (N_STAGES in the package: 7 fixed stages plus
// one stage per four bits of the 25-bit distance square root). A new item can be taken every
// cycle when m_ready stays high. Each stage holds its item only while the stage after it is
// full and stalled, so empty stages keep filling while a result waits.
module line_endpoint_angle_snap
    import les_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_start_x,
    input  logic signed [COORD_BITS-1:0] s_start_y,
    input  logic signed [COORD_BITS-1:0] s_end_x,
    input  logic signed [COORD_BITS-1:0] s_end_y,
    input  logic                         s_snap_45,
    input  logic                         s_snap_30,
    input  logic                         s_centre,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [OUT_BITS-1:0]   m_line_start_x,
    output logic signed [OUT_BITS-1:0]   m_line_start_y,
    output logic signed [OUT_BITS-1:0]   m_line_end_x,
    output logic signed [OUT_BITS-1:0]   m_line_end_y
);

    localparam logic signed [ACC_BITS-1:0] TRUNC_BIAS =
        ACC_BITS'((64'sd1 <<< PROD_SHIFT) - 64'sd1);

    // pipeline control
    logic [N_STAGES-1:0] v_reg;
    logic [N_STAGES-1:0] v_in;
    logic [N_STAGES-1:0] en;
    logic [N_STAGES-1:0] ld;

    ctx_t ctx_reg  [N_STAGES];
    ctx_t ctx_next [N_STAGES];
    ctx_t ctx_in;

    // stage a: differences and comparison slots
    logic [COORD_BITS-1:0] adx_a_reg, ady_a_reg;
    logic [TAN_BITS-1:0]   slot_t_a_reg [NSLOT];
    ang_t                  slot_ang_a_reg [NSLOT];
    logic [NSLOT-1:0]      slot_en_a_reg;
    logic [TAN_BITS-1:0]   slot_t_next [NSLOT];
    ang_t                  slot_ang_next [NSLOT];
    logic [NSLOT-1:0]      slot_en_next;
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]   adx_w, ady_w;

    // stage b: squares and tangent products
    logic [SQR_BITS-1:0]   sqx_b_reg, sqy_b_reg;
    logic [MID_BITS-1:0]   prod_b_reg [NSLOT];
    logic [COORD_BITS-1:0] ady_b_reg;
    ang_t                  slot_ang_b_reg [NSLOT];
    logic [NSLOT-1:0]      slot_en_b_reg;

    // stage c: sum of squares and chosen angle
    logic [SUMSQ_BITS-1:0] sum_c_reg;
    ang_t                  ang_c;
    logic [MID_BITS-1:0]   ady_sh;

    // square root stages
    sq_t sq_reg [SQ_STAGES];
    sq_t sq_in  [SQ_STAGES];
    sq_t sq_out [SQ_STAGES];

    // stage d: distance times cos and sin
    logic [PROD_BITS-1:0] px_d_reg, py_d_reg;
    logic [CS_BITS-1:0]   cs_x, cs_y;

    // stage e1: exact diagonal sums
    logic signed [ACC_BITS-1:0] nx_e1_reg, ny_e1_reg;
    logic signed [ACC_BITS-1:0] nx_next, ny_next;

    // stage e2: truncated and selected end point
    logic signed [QUO_BITS-1:0] fx_e2_reg, fy_e2_reg;
    logic signed [QUO_BITS-1:0] fx_next, fy_next;
    logic signed [ACC_BITS-1:0] bx, by;

    // stage f: centering and saturation
    logic signed [OUT_BITS-1:0] line_start_x_reg, line_start_y_reg;
    logic signed [OUT_BITS-1:0] line_end_x_reg, line_end_y_reg;
    logic signed [CTR_BITS-1:0] cx, cy;

    // valid chain: a stage advances when it is empty or its successor advances
    assign v_in[0] = s_valid;
    assign v_in[N_STAGES-1:1] = v_reg[N_STAGES-2:0];
    assign en[N_STAGES-1] = !v_reg[N_STAGES-1] || m_ready;
    for (genvar i = 0; i < N_STAGES - 1; i++) begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end
    assign ld = en & v_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < N_STAGES; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[N_STAGES-1];

    // differences and slot setup from the input transfer
    always_comb begin
        dx    = ((COORD_BITS+1)'(s_end_x) - (COORD_BITS+1)'(s_start_x));
        dy    = ((COORD_BITS+1)'(s_end_y) - (COORD_BITS+1)'(s_start_y));
        adx_w = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
        ady_w = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);

        ctx_in.sx   = s_start_x;
        ctx_in.sy   = s_start_y;
        ctx_in.ex   = s_end_x;
        ctx_in.ey   = s_end_y;
        ctx_in.s45  = s_snap_45;
        ctx_in.s30  = s_snap_30;
        ctx_in.snap = s_snap_45 || s_snap_30;
        ctx_in.ctr  = s_centre;
        ctx_in.negx = dx[COORD_BITS];
        ctx_in.negy = dy[COORD_BITS];
        ctx_in.dxz  = (dx == '0);
        ctx_in.ang  = ANG_90;

        // midpoint between each pair of neighboring allowed angles
        slot_t_next[0]   = s_snap_30 ? TAN_15 : TAN_22_5;
        slot_ang_next[0] = ANG_0;
        slot_en_next[0]  = 1'b1;
        if (s_snap_45 && s_snap_30) begin
            slot_t_next[1]   = TAN_37_5;
            slot_ang_next[1] = ANG_30;
            slot_t_next[2]   = TAN_52_5;
            slot_ang_next[2] = ANG_45;
            slot_t_next[3]   = TAN_75;
            slot_ang_next[3] = ANG_60;
            slot_en_next[3:1] = 3'b111;
        end else if (s_snap_30) begin
            slot_t_next[1]   = TAN_45;
            slot_ang_next[1] = ANG_30;
            slot_t_next[2]   = TAN_75;
            slot_ang_next[2] = ANG_60;
            slot_t_next[3]   = TAN_75;
            slot_ang_next[3] = ANG_60;
            slot_en_next[3:1] = 3'b011;
        end else begin
            slot_t_next[1]   = TAN_67_5;
            slot_ang_next[1] = ANG_45;
            slot_t_next[2]   = TAN_67_5;
            slot_ang_next[2] = ANG_45;
            slot_t_next[3]   = TAN_67_5;
            slot_ang_next[3] = ANG_45;
            slot_en_next[3:1] = 3'b001;
        end
    end

    // context moves along; the angle is filled in at stage c
    always_comb begin
        ctx_next[0] = ctx_in;
        for (int i = 1; i < N_STAGES; i++) begin
            ctx_next[i] = ctx_reg[i-1];
        end
        ctx_next[ST_C].ang = ang_c;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < N_STAGES; i++) begin
            if (ld[i]) begin
                ctx_reg[i] <= ctx_next[i];
            end
        end
    end

    // stage a registers
    always_ff @(posedge aclk) begin
        if (ld[ST_A]) begin
            adx_a_reg     <= adx_w[COORD_BITS-1:0];
            ady_a_reg     <= ady_w[COORD_BITS-1:0];
            slot_en_a_reg <= slot_en_next;
            for (int i = 0; i < NSLOT; i++) begin
                slot_t_a_reg[i]   <= slot_t_next[i];
                slot_ang_a_reg[i] <= slot_ang_next[i];
            end
        end
    end

    // stage b: squares and |dx| times each midpoint tangent
    always_ff @(posedge aclk) begin
        if (ld[ST_B]) begin
            sqx_b_reg     <= SQR_BITS'(adx_a_reg) * SQR_BITS'(adx_a_reg);
            sqy_b_reg     <= SQR_BITS'(ady_a_reg) * SQR_BITS'(ady_a_reg);
            ady_b_reg     <= ady_a_reg;
            slot_en_b_reg <= slot_en_a_reg;
            for (int i = 0; i < NSLOT; i++) begin
                prod_b_reg[i]     <= MID_BITS'(adx_a_reg) * MID_BITS'(slot_t_a_reg[i]);
                slot_ang_b_reg[i] <= slot_ang_a_reg[i];
            end
        end
    end

    // stage c: lowest slot whose scaled |dy| is below the product wins; zero dx picks 90 degrees
    always_comb begin
        ady_sh = MID_BITS'({ady_b_reg, {TRIG_FRAC_BITS{1'b0}}});
        ang_c  = ANG_90;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (slot_en_b_reg[i] && (ady_sh < prod_b_reg[i])) begin
                ang_c = slot_ang_b_reg[i];
            end
        end
        if (ctx_reg[ST_B].dxz) begin
            ang_c = ANG_90;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_C]) begin
            sum_c_reg <= SUMSQ_BITS'(sqx_b_reg) + SUMSQ_BITS'(sqy_b_reg);
        end
    end

    // square root of sum * 2^(2*DIST_FRAC), SQ_PER_STAGE root bits per stage
    always_comb begin
        sq_in[0].rad  = {1'b0, sum_c_reg, {(2*DIST_FRAC){1'b0}}};
        sq_in[0].rem  = '0;
        sq_in[0].root = '0;
    end

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        if (k > 0) begin : g_link
            assign sq_in[k] = sq_reg[k-1];
        end

        always_comb begin
            sq_out[k] = sq_in[k];
            for (int j = 0; j < SQ_PER_STAGE; j++) begin
                if (k * SQ_PER_STAGE + j < ROOT_BITS) begin
                    sq_out[k] = sqrt_step(sq_out[k]);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ld[ST_SQ0+k]) begin
                sq_reg[k] <= sq_out[k];
            end
        end
    end

    // stage d: distance scaled by cos and sin of the chosen diagonal
    always_comb begin
        unique case (ctx_reg[ST_D-1].ang)
            ANG_30: begin
                cs_x = CS_30;
                cs_y = CS_60;
            end
            ANG_60: begin
                cs_x = CS_60;
                cs_y = CS_30;
            end
            default: begin
                cs_x = CS_45;
                cs_y = CS_45;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_D]) begin
            px_d_reg <= PROD_BITS'(sq_reg[SQ_STAGES-1].root) * PROD_BITS'(cs_x);
            py_d_reg <= PROD_BITS'(sq_reg[SQ_STAGES-1].root) * PROD_BITS'(cs_y);
        end
    end

    // stage e1: start in the product format plus or minus the product
    always_comb begin
        nx_next = ACC_BITS'(ctx_reg[ST_D].sx) <<< PROD_SHIFT;
        ny_next = ACC_BITS'(ctx_reg[ST_D].sy) <<< PROD_SHIFT;
        if (ctx_reg[ST_D].negx) begin
            nx_next = nx_next - $signed(ACC_BITS'(px_d_reg));
        end else begin
            nx_next = nx_next + $signed(ACC_BITS'(px_d_reg));
        end
        if (ctx_reg[ST_D].negy) begin
            ny_next = ny_next - $signed(ACC_BITS'(py_d_reg));
        end else begin
            ny_next = ny_next + $signed(ACC_BITS'(py_d_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_E1]) begin
            nx_e1_reg <= nx_next;
            ny_e1_reg <= ny_next;
        end
    end

    // stage e2: truncate toward zero and pick the end point by angle
    always_comb begin
        bx = nx_e1_reg + (nx_e1_reg[ACC_BITS-1] ? TRUNC_BIAS : ACC_BITS'(0));
        by = ny_e1_reg + (ny_e1_reg[ACC_BITS-1] ? TRUNC_BIAS : ACC_BITS'(0));
        fx_next = QUO_BITS'(ctx_reg[ST_E1].ex);
        fy_next = QUO_BITS'(ctx_reg[ST_E1].ey);
        if (ctx_reg[ST_E1].snap) begin
            case (ctx_reg[ST_E1].ang)
                ANG_0: begin
                    fy_next = QUO_BITS'(ctx_reg[ST_E1].sy);
                end
                ANG_90: begin
                    fx_next = QUO_BITS'(ctx_reg[ST_E1].sx);
                end
                default: begin
                    fx_next = QUO_BITS'(bx >>> PROD_SHIFT);
                    fy_next = QUO_BITS'(by >>> PROD_SHIFT);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_E2]) begin
            fx_e2_reg <= fx_next;
            fy_e2_reg <= fy_next;
        end
    end

    // stage f: mirror the start when centering, then saturate
    always_comb begin
        cx = CTR_BITS'(ctx_reg[ST_E2].sx);
        cy = CTR_BITS'(ctx_reg[ST_E2].sy);
        if (ctx_reg[ST_E2].ctr) begin
            cx = (cx <<< 1) - CTR_BITS'(fx_e2_reg);
            cy = (cy <<< 1) - CTR_BITS'(fy_e2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_F]) begin
            line_start_x_reg <= sat_out(cx);
            line_start_y_reg <= sat_out(cy);
            line_end_x_reg   <= sat_out(CTR_BITS'(fx_e2_reg));
            line_end_y_reg   <= sat_out(CTR_BITS'(fy_e2_reg));
        end
    end

    assign m_line_start_x = line_start_x_reg;
    assign m_line_start_y = line_start_y_reg;
    assign m_line_end_x   = line_end_x_reg;
    assign m_line_end_y   = line_end_y_reg;

    // a 45 degree pick needs the 45 degree modifier
    a_ang45_needs_s45: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_C] && ctx_reg[ST_C].snap && (ctx_reg[ST_C].ang == ANG_45)
        |-> ctx_reg[ST_C].s45)
        else $error("45 degree snap chosen without snap_45");

    // 30 and 60 degree picks need the 30 degree modifier
    a_ang30_needs_s30: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_C] && ctx_reg[ST_C].snap &&
        ((ctx_reg[ST_C].ang == ANG_30) || (ctx_reg[ST_C].ang == ANG_60))
        |-> ctx_reg[ST_C].s30)
        else $error("30 or 60 degree snap chosen without snap_30");

    // zero dx always snaps to vertical
    a_dxz_vertical: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_C] && ctx_reg[ST_C].dxz |-> (ctx_reg[ST_C].ang == ANG_90))
        else $error("zero dx did not snap to 90 degrees");

    // horizontal snap keeps the end on the start row
    a_horizontal_row: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_E2] && ctx_reg[ST_E2].snap && (ctx_reg[ST_E2].ang == ANG_0)
        |-> (fy_e2_reg == QUO_BITS'(ctx_reg[ST_E2].sy)))
        else $error("horizontal snap moved end y off the start row");

endmodule
